// ===== rtl/stcc_pkg.sv =====
// Shared types, codes and helper functions of the segmented toy CPU core.
package stcc_pkg;

    // Default sizes of the core
    localparam int unsigned MEM_WORDS_DEF = 128;
    localparam int unsigned NUM_REGS_DEF  = 8;
    localparam int unsigned WORD_BITS_DEF = 32;
    localparam int unsigned ARG_BITS_DEF  = 16;

    // Fixed field widths
    localparam int unsigned PC_BITS        = 16;
    localparam int unsigned BASE_BITS      = 7;
    localparam int unsigned SIZE_BITS      = 8;
    localparam int unsigned OPER_BITS      = 2;
    localparam int unsigned TARGET_BITS    = 7;
    localparam int unsigned VALUE_BITS     = 32;
    localparam int unsigned AC_OUT_BITS    = 32;
    localparam int unsigned STATUS_BITS    = 3;
    localparam int unsigned OPCODE_BITS    = 10;
    localparam int unsigned CFG_INDEX_BITS = 2;
    localparam int unsigned CFG_DATA_BITS  = 8;

    // Configuration register indexes and reset values
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SEG_BASE = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SEG_SIZE = 2'd1;
    localparam logic [BASE_BITS-1:0]      SEG_BASE_RESET = 7'd0;
    localparam logic [SIZE_BITS-1:0]      SEG_SIZE_RESET = 8'd128;

    // Item operations
    localparam logic [OPER_BITS-1:0] OPN_EXEC = 2'd0;
    localparam logic [OPER_BITS-1:0] OPN_WMEM = 2'd1;
    localparam logic [OPER_BITS-1:0] OPN_WREG = 2'd2;

    // Instruction opcodes
    localparam logic [OPCODE_BITS-1:0] OPC_ADD   = 10'd0;
    localparam logic [OPCODE_BITS-1:0] OPC_SUB   = 10'd1;
    localparam logic [OPCODE_BITS-1:0] OPC_CMP   = 10'd2;
    localparam logic [OPCODE_BITS-1:0] OPC_IFGT  = 10'd3;
    localparam logic [OPCODE_BITS-1:0] OPC_NOP   = 10'd4;
    localparam logic [OPCODE_BITS-1:0] OPC_JUMP  = 10'd5;
    localparam logic [OPCODE_BITS-1:0] OPC_HALT  = 10'd6;
    localparam logic [OPCODE_BITS-1:0] OPC_SYSC  = 10'd7;
    localparam logic [OPCODE_BITS-1:0] OPC_LOAD  = 10'd8;
    localparam logic [OPCODE_BITS-1:0] OPC_STORE = 10'd9;

    // Result status; the stop code uses the write-done value for running
    typedef enum logic [STATUS_BITS-1:0] {
        ST_WRITE,
        ST_STEP,
        ST_SYSC,
        ST_SEGV,
        ST_BADOP,
        ST_HALT,
        ST_ADDR
    } status_t;

    localparam status_t STOP_NONE = ST_WRITE;

    // Sequencer states
    typedef enum logic [1:0] {
        ENG_IDLE,
        ENG_FETCH,
        ENG_EXEC,
        ENG_LOAD
    } eng_state_t;

    // Reduce a memory offset below 512 modulo the memory depth (m >= 16)
    function automatic logic [8:0] mem_wrap(input logic [8:0] x, input int unsigned m);
        logic [8:0] r;
        r = x;
        for (int k = 4; k >= 0; k--) begin
            if (int'(r) >= int'(m << k)) begin
                r = r - 9'(m << k);
            end
        end
        return r;
    endfunction

    // Reduce a 3-bit register field modulo the register count (n >= 2)
    function automatic logic [3:0] reg_wrap(input logic [2:0] x, input int unsigned n);
        logic [3:0] r;
        r = 4'(x);
        for (int k = 2; k >= 0; k--) begin
            if (int'(r) >= int'(n << k)) begin
                r = r - 4'(n << k);
            end
        end
        return r;
    endfunction

endpackage

// ===== rtl/stcc_regfile.sv =====
// Data register file: one write port, two registered read ports, reset by valid bits.
module stcc_regfile #(
    parameter int unsigned NUM_REGS  = stcc_pkg::NUM_REGS_DEF,
    parameter int unsigned WORD_BITS = stcc_pkg::WORD_BITS_DEF,
    localparam int unsigned RW       = $clog2(NUM_REGS)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 wr_en,
    input  logic [RW-1:0]        wr_addr,
    input  logic [WORD_BITS-1:0] wr_data,
    input  logic                 rd_en,
    input  logic [RW-1:0]        rd_addr_a,
    input  logic [RW-1:0]        rd_addr_b,
    output logic [WORD_BITS-1:0] rd_data_a,
    output logic [WORD_BITS-1:0] rd_data_b
);

    logic [WORD_BITS-1:0] regs [NUM_REGS];
    logic [NUM_REGS-1:0]  vld_reg;
    logic [WORD_BITS-1:0] rda_reg;
    logic [WORD_BITS-1:0] rdb_reg;
    logic                 vlda_reg;
    logic                 vldb_reg;

    // Write the array
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            regs[wr_addr] <= wr_data;
        end
    end

    // Mark written entries; reset makes every entry read as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (wr_en) begin
            vld_reg[wr_addr] <= 1'b1;
        end
    end

    // Register both read ports
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rda_reg  <= regs[rd_addr_a];
            rdb_reg  <= regs[rd_addr_b];
            vlda_reg <= vld_reg[rd_addr_a];
            vldb_reg <= vld_reg[rd_addr_b];
        end
    end

    assign rd_data_a = vlda_reg ? rda_reg : '0;
    assign rd_data_b = vldb_reg ? rdb_reg : '0;

endmodule

// ===== rtl/segmented_toy_cpu_core_top.sv =====
// Top level of the segmented toy CPU core: input buffer, sequencer, program memory, result register.
//
// Usage:
//   Items enter on the s_ channel (operation, target_index, write_value) and each
//   gives one result on the m_ channel (status, program_counter, accumulator).
//   Configuration (segment base and size) is written on the cfg_ channel, which
//   is always ready; write it only while the core is idle.
//   An accepted item waits in a one-entry input buffer, so the next transfer is
//   taken while the core still works on the previous one.
//   Path from input transfer to result: the input buffer, then the result register
//   for memory or register writes and for steps of a stopped core; an executed
//   instruction also passes the FETCH and EXEC states, and LOAD the LOAD state.
//   Throughput: one write item per cycle while the receiver takes the results;
//   an instruction holds the sequencer through the instruction fetch, the
//   register read and the execute, and LOAD reads the single-port program
//   memory a second time.
//   Reset clears registers, accumulator, PC and stop code and sets the segment to
//   base 0, size 128. Memory words read undefined until written.
//   When the receiver stalls, the result holds in the output register and the
//   core waits before producing the next one; the input buffer still fills.
module segmented_toy_cpu_core_top #(
    parameter int unsigned MEM_WORDS = stcc_pkg::MEM_WORDS_DEF,
    parameter int unsigned NUM_REGS  = stcc_pkg::NUM_REGS_DEF,
    parameter int unsigned WORD_BITS = stcc_pkg::WORD_BITS_DEF,
    parameter int unsigned ARG_BITS  = stcc_pkg::ARG_BITS_DEF
) (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    // configuration writes
    input  logic                                       cfg_valid,
    output logic                                       cfg_ready,
    input  logic [stcc_pkg::CFG_INDEX_BITS-1:0]        cfg_index,
    input  logic [stcc_pkg::CFG_DATA_BITS-1:0]         cfg_data,
    // input items
    input  logic                                       s_valid,
    output logic                                       s_ready,
    input  logic [stcc_pkg::OPER_BITS-1:0]             s_operation,
    input  logic [stcc_pkg::TARGET_BITS-1:0]           s_target_index,
    input  logic signed [stcc_pkg::VALUE_BITS-1:0]     s_write_value,
    // results
    output logic                                       m_valid,
    input  logic                                       m_ready,
    output logic [stcc_pkg::STATUS_BITS-1:0]           m_status,
    output logic signed [stcc_pkg::PC_BITS-1:0]        m_program_counter,
    output logic signed [stcc_pkg::AC_OUT_BITS-1:0]    m_accumulator
);

    localparam int unsigned AW = $clog2(MEM_WORDS);
    localparam int unsigned RW = $clog2(NUM_REGS);
    localparam int unsigned PW = stcc_pkg::PC_BITS;
    localparam int unsigned SW = stcc_pkg::SIZE_BITS;

    // Configuration registers
    logic [stcc_pkg::BASE_BITS-1:0] seg_base_reg;
    logic [SW-1:0]                  seg_size_reg;

    // Input buffer
    logic                                   buf_valid_reg;
    logic [stcc_pkg::OPER_BITS-1:0]         buf_op_reg;
    logic [stcc_pkg::TARGET_BITS-1:0]       buf_target_reg;
    logic signed [stcc_pkg::VALUE_BITS-1:0] buf_value_reg;

    // Architectural state and sequencer
    stcc_pkg::eng_state_t state_reg, state_next;
    logic [PW-1:0]        pc_reg, pc_next;
    logic [WORD_BITS-1:0] ac_reg, ac_next;
    stcc_pkg::status_t    stop_reg, stop_next;
    logic [RW-1:0]        ri_reg;

    // Program memory
    logic [WORD_BITS-1:0] mem [MEM_WORDS];
    logic [WORD_BITS-1:0] mem_rdata_reg;
    logic                 mem_re;
    logic                 mem_we;
    logic [AW-1:0]        mem_addr;
    logic [WORD_BITS-1:0] mem_wdata;

    // Register file port
    logic                 rf_we;
    logic [RW-1:0]        rf_waddr;
    logic [WORD_BITS-1:0] rf_wdata;
    logic                 rf_re;
    logic [WORD_BITS-1:0] rd_i;
    logic [WORD_BITS-1:0] rd_j;

    // Result register
    logic                    m_valid_reg;
    stcc_pkg::status_t       m_status_reg;
    logic [PW-1:0]           m_pc_reg;
    logic [stcc_pkg::AC_OUT_BITS-1:0] m_ac_reg;
    logic                    out_free;
    logic                    out_load;
    stcc_pkg::status_t       out_status;

    logic pop;
    logic in_xfer;

    // Decode of the fetched word
    logic [stcc_pkg::OPCODE_BITS-1:0] opc;
    logic [RW-1:0]                    ri;
    logic [RW-1:0]                    rj;
    logic signed [ARG_BITS-1:0]       arg_raw;
    logic [WORD_BITS-1:0]             arg_w;
    logic [PW-1:0]                    arg_pc;
    logic [WORD_BITS-1:0]             sum;
    logic [WORD_BITS-1:0]             add_res;
    logic [WORD_BITS-1:0]             sub_res;
    logic                             addr_bad;
    logic                             ac_pos;
    logic                             pc_bad;
    logic [PW-1:0]                    pc_inc;
    logic [AW-1:0]                    fetch_addr;
    logic [AW-1:0]                    data_addr;
    logic [AW-1:0]                    wmem_addr;

    assign cfg_ready = 1'b1;

    // Hold the segment configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seg_base_reg <= stcc_pkg::SEG_BASE_RESET;
            seg_size_reg <= stcc_pkg::SEG_SIZE_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                stcc_pkg::CFG_SEG_BASE: seg_base_reg <= cfg_data[stcc_pkg::BASE_BITS-1:0];
                stcc_pkg::CFG_SEG_SIZE: seg_size_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Input buffer: take a transfer when empty or when the entry leaves this cycle
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = !buf_valid_reg || pop;
    assign in_xfer  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buf_valid_reg <= 1'b0;
        end else if (in_xfer) begin
            buf_valid_reg <= 1'b1;
        end else if (pop) begin
            buf_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            buf_op_reg     <= s_operation;
            buf_target_reg <= s_target_index;
            buf_value_reg  <= s_write_value;
        end
    end

    // Decode the instruction word held at the memory output
    assign opc     = mem_rdata_reg[stcc_pkg::OPCODE_BITS-1:0];
    assign ri      = RW'(stcc_pkg::reg_wrap(mem_rdata_reg[12:10], NUM_REGS));
    assign rj      = RW'(stcc_pkg::reg_wrap(mem_rdata_reg[15:13], NUM_REGS));
    assign arg_raw = mem_rdata_reg[16 +: ARG_BITS];
    assign arg_w   = WORD_BITS'(arg_raw);
    assign arg_pc  = PW'(arg_raw);

    // Operand add, then the register update
    assign sum      = rd_j + arg_w;
    assign add_res  = rd_i + sum;
    assign sub_res  = rd_i - sum;
    assign addr_bad = sum[WORD_BITS-1] || (sum >= WORD_BITS'(seg_size_reg));
    assign ac_pos   = !ac_reg[WORD_BITS-1] && (ac_reg != '0);
    assign pc_bad   = pc_reg[PW-1] || (pc_reg >= PW'(seg_size_reg));
    assign pc_inc   = pc_reg + 1'b1;

    // Fetch and data addresses are segment-relative; they and the write-item address wrap around the memory
    assign fetch_addr = AW'(stcc_pkg::mem_wrap(9'(seg_base_reg) + 9'(pc_reg[SW-1:0]),
                                               MEM_WORDS));
    assign data_addr  = AW'(stcc_pkg::mem_wrap(9'(seg_base_reg) + 9'(sum[SW-1:0]),
                                               MEM_WORDS));
    assign wmem_addr  = AW'(stcc_pkg::mem_wrap(9'(buf_target_reg), MEM_WORDS));

    // Sequencer: next state, memory and register file accesses, results
    always_comb begin
        state_next = state_reg;
        pc_next    = pc_reg;
        ac_next    = ac_reg;
        stop_next  = stop_reg;
        pop        = 1'b0;
        out_load   = 1'b0;
        out_status = stcc_pkg::ST_WRITE;
        mem_re     = 1'b0;
        mem_we     = 1'b0;
        mem_addr   = fetch_addr;
        mem_wdata  = WORD_BITS'(buf_value_reg);
        rf_we      = 1'b0;
        rf_waddr   = RW'(buf_target_reg);
        rf_wdata   = WORD_BITS'(buf_value_reg);
        rf_re      = 1'b0;

        case (state_reg)
            stcc_pkg::ENG_IDLE: begin
                if (buf_valid_reg && out_free) begin
                    pop = 1'b1;
                    case (buf_op_reg)
                        stcc_pkg::OPN_EXEC: begin
                            if (stop_reg != stcc_pkg::STOP_NONE) begin
                                out_load   = 1'b1;
                                out_status = stop_reg;
                            end else if (pc_bad) begin
                                stop_next  = stcc_pkg::ST_SEGV;
                                out_load   = 1'b1;
                                out_status = stcc_pkg::ST_SEGV;
                            end else begin
                                mem_re     = 1'b1;
                                state_next = stcc_pkg::ENG_FETCH;
                            end
                        end
                        stcc_pkg::OPN_WMEM: begin
                            mem_we   = 1'b1;
                            mem_addr = wmem_addr;
                            out_load = 1'b1;
                        end
                        stcc_pkg::OPN_WREG: begin
                            if (int'(buf_target_reg) < int'(NUM_REGS)) begin
                                rf_we = 1'b1;
                            end else if (int'(buf_target_reg) == int'(NUM_REGS)) begin
                                pc_next   = buf_value_reg[PW-1:0];
                                stop_next = stcc_pkg::STOP_NONE;
                            end
                            out_load = 1'b1;
                        end
                        default: begin
                            out_load = 1'b1;
                        end
                    endcase
                end
            end
            stcc_pkg::ENG_FETCH: begin
                // Read both register operands of the fetched word
                rf_re      = 1'b1;
                state_next = stcc_pkg::ENG_EXEC;
            end
            stcc_pkg::ENG_EXEC: begin
                if (out_free) begin
                    state_next = stcc_pkg::ENG_IDLE;
                    out_load   = 1'b1;
                    out_status = stcc_pkg::ST_STEP;
                    rf_waddr   = ri;
                    case (opc)
                        stcc_pkg::OPC_ADD: begin
                            rf_we    = 1'b1;
                            rf_wdata = add_res;
                            ac_next  = add_res;
                            pc_next  = pc_inc;
                        end
                        stcc_pkg::OPC_SUB: begin
                            rf_we    = 1'b1;
                            rf_wdata = sub_res;
                            ac_next  = sub_res;
                            pc_next  = pc_inc;
                        end
                        stcc_pkg::OPC_CMP: begin
                            ac_next = sub_res;
                            pc_next = pc_inc;
                        end
                        stcc_pkg::OPC_IFGT: begin
                            pc_next = ac_pos ? arg_pc : pc_inc;
                        end
                        stcc_pkg::OPC_NOP: begin
                            pc_next = pc_inc;
                        end
                        stcc_pkg::OPC_JUMP: begin
                            pc_next = arg_pc;
                        end
                        stcc_pkg::OPC_HALT: begin
                            stop_next  = stcc_pkg::ST_HALT;
                            out_status = stcc_pkg::ST_HALT;
                        end
                        stcc_pkg::OPC_SYSC: begin
                            pc_next    = pc_inc;
                            out_status = stcc_pkg::ST_SYSC;
                        end
                        stcc_pkg::OPC_LOAD, stcc_pkg::OPC_STORE: begin
                            mem_addr = data_addr;
                            if (addr_bad) begin
                                stop_next  = stcc_pkg::ST_ADDR;
                                out_status = stcc_pkg::ST_ADDR;
                            end else if (opc == stcc_pkg::OPC_LOAD) begin
                                // Second memory access; the LOAD state writes back the read word
                                mem_re     = 1'b1;
                                out_load   = 1'b0;
                                state_next = stcc_pkg::ENG_LOAD;
                            end else begin
                                mem_we    = 1'b1;
                                mem_wdata = rd_i;
                                ac_next   = rd_i;
                                pc_next   = pc_inc;
                            end
                        end
                        default: begin
                            stop_next  = stcc_pkg::ST_BADOP;
                            out_status = stcc_pkg::ST_BADOP;
                        end
                    endcase
                end
            end
            stcc_pkg::ENG_LOAD: begin
                if (out_free) begin
                    rf_we      = 1'b1;
                    rf_waddr   = ri_reg;
                    rf_wdata   = mem_rdata_reg;
                    ac_next    = mem_rdata_reg;
                    pc_next    = pc_inc;
                    out_load   = 1'b1;
                    out_status = stcc_pkg::ST_STEP;
                    state_next = stcc_pkg::ENG_IDLE;
                end
            end
            default: begin
                state_next = stcc_pkg::ENG_IDLE;
            end
        endcase
    end

    // Advance sequencer and architectural state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= stcc_pkg::ENG_IDLE;
            pc_reg    <= '0;
            ac_reg    <= '0;
            stop_reg  <= stcc_pkg::STOP_NONE;
        end else begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            ac_reg    <= ac_next;
            stop_reg  <= stop_next;
        end
    end

    // Keep the destination register for the load write-back
    always_ff @(posedge aclk) begin
        if (state_reg == stcc_pkg::ENG_EXEC) begin
            ri_reg <= ri;
        end
    end

    // Program memory: one access per cycle, registered read data
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        if (mem_re) begin
            mem_rdata_reg <= mem[mem_addr];
        end
    end

    stcc_regfile #(
        .NUM_REGS  (NUM_REGS),
        .WORD_BITS (WORD_BITS)
    ) u_regfile (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr_en     (rf_we),
        .wr_addr   (rf_waddr),
        .wr_data   (rf_wdata),
        .rd_en     (rf_re),
        .rd_addr_a (ri),
        .rd_addr_b (rj),
        .rd_data_a (rd_i),
        .rd_data_b (rd_j)
    );

    // Result register: load a result, drop it on transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_status_reg <= out_status;
            m_pc_reg     <= pc_next;
            m_ac_reg     <= ac_next[stcc_pkg::AC_OUT_BITS-1:0];
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_status          = m_status_reg;
    assign m_program_counter = m_pc_reg;
    assign m_accumulator     = m_ac_reg;

    // A fetch always moves on to execute
    a_fetch_to_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == stcc_pkg::ENG_FETCH) |=> (state_reg == stcc_pkg::ENG_EXEC))
        else $error("fetch not followed by execute");

    // A stopped core never executes an instruction
    a_exec_running: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == stcc_pkg::ENG_EXEC) |-> (stop_reg == stcc_pkg::STOP_NONE))
        else $error("instruction executed while stopped");

    // A reported halt leaves the core stopped
    a_halt_sticks: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && (out_status == stcc_pkg::ST_HALT)) |=> (stop_reg == stcc_pkg::ST_HALT))
        else $error("halt status without stop");

    // Results are loaded only into a free output register
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> !$past(out_load))
        else $error("pending result overwritten");

endmodule
